### rtl/ted_pkg.sv
`timescale 1ns / 1ps
// Package: shared widths, payload types and calendar tables for the elapsed time block.
package ted_pkg;

   localparam int unsigned MAX_YEAR   = 9999;
   localparam int unsigned YEAR_W     = 14;
   localparam int unsigned DAY_NUM_W  = 22;

   // floor(p / 100) = (p * RECIP_100) >> RECIP_SHIFT, exact for any 14-bit p
   localparam int unsigned RECIP_100   = 5243;
   localparam int unsigned RECIP_SHIFT = 19;

   typedef enum logic {
      ACTION_STORE   = 1'b0,
      ACTION_MEASURE = 1'b1
   } action_type;

   typedef struct packed {
      logic        action;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [9:0]  millisecond;
   } req_payload_type;

   typedef struct packed {
      logic        invalid;
      logic [21:0] elapsed_days;
      logic [4:0]  elapsed_hours;
      logic [5:0]  elapsed_minutes;
      logic [5:0]  elapsed_seconds;
      logic [9:0]  elapsed_milliseconds;
   } rsp_payload_type;

   // Field order gives lexicographic ordering when compared as a vector
   typedef struct packed {
      logic [21:0] day_number;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [9:0]  millisecond;
   } stamp_type;

   typedef struct packed {
      logic        invalid;
      logic [21:0] day_number;
   } day_info_type;

   typedef struct packed {
      logic      invalid;
      logic      action;
      stamp_type stamp;
   } stage_type;

   function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                        len = leap ? 5'd29 : 5'd28;
         default:                                     len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [8:0] days_before_month(input logic [3:0] month);
      logic [8:0] days;
      case (month)
         4'd1:    days = 9'd0;
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

### rtl/ted_channel_if.sv
`timescale 1ns / 1ps
// Interfaces: valid/ready channels for requests and responses.
interface ted_req_if;
   logic                     valid;
   logic                     ready;
   ted_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ted_rsp_if;
   logic                     valid;
   logic                     ready;
   ted_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/timestamp_elapsed_difference.sv
`timescale 1ns / 1ps
// Top level: Gregorian timestamp elapsed-time block with a stored reference.
//
// Usage
//   req carries one timestamp and an action. A store request keeps the
//   timestamp as the reference and answers a zero duration; a measure
//   request answers the absolute time between it and the reference, as
//   days, hours, minutes, seconds and milliseconds. Any field out of range
//   answers invalid with a zero duration and leaves the reference alone.
//   Every request gives exactly one response on rsp, in request order.
// Timing
//   Three register stages: input register, day-number register, response
//   register; a request passes through them in that order to rsp. One request
//   per cycle is sustained while rsp does not stall; the reference is written
//   at the edge where a store leaves the day-number stage, so a measure right
//   behind a store already sees the new reference.
// Reset
//   Clears all stage valid flags and sets the reference to day 0, 00:00:00.000.
//   req.ready is held low while reset is high, so no request is taken then.
// Back-pressure
//   When rsp stalls, the response register holds and each stage fills in turn;
//   req.ready drops only once all three stages are occupied.
module timestamp_elapsed_difference (
   input  logic      clock,
   input  logic      reset,
   ted_req_if.sink   req,
   ted_rsp_if.source rsp
);

   // Input register
   logic                     s1_valid_ff, s1_valid_in;
   ted_pkg::req_payload_type s1_item_ff, s1_item_in;
   // Day-number register
   logic                     s2_valid_ff, s2_valid_in;
   ted_pkg::stage_type       s2_stage_ff, s2_stage_in;
   // Response register
   logic                     rsp_valid_ff, rsp_valid_in;
   ted_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;
   // Reference timestamp
   ted_pkg::stamp_type       ref_stamp_ff, ref_stamp_in;

   ted_pkg::day_info_type    day_info;
   ted_pkg::rsp_payload_type result;
   logic out_ready, s2_ready, s1_ready;
   logic ref_write;

   // Each stage takes a new request when empty or when its content moves on
   assign out_ready = !rsp_valid_ff || rsp.ready;
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   // Hold off requests during reset
   assign req.ready = s1_ready && !reset;

   ted_day_number u_day_number (
      .item (s1_item_ff),
      .info (day_info)
   );

   ted_elapsed u_elapsed (
      .item      (s2_stage_ff),
      .ref_stamp (ref_stamp_ff),
      .result    (result)
   );

   // Update the reference as a valid store leaves the day-number stage
   assign ref_write = s2_valid_ff && out_ready && !s2_stage_ff.invalid
                   && (s2_stage_ff.action == ted_pkg::ACTION_STORE);

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_item_in   = s1_item_ff;
      s2_valid_in  = s2_valid_ff;
      s2_stage_in  = s2_stage_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ref_stamp_in = ref_stamp_ff;

      // Advance the input stage
      if (s1_ready) begin
         s1_valid_in = req.valid;
         s1_item_in  = req.payload;
      end

      // Advance the day-number stage
      if (s2_ready) begin
         s2_valid_in                   = s1_valid_ff;
         s2_stage_in.invalid           = day_info.invalid;
         s2_stage_in.action            = s1_item_ff.action;
         s2_stage_in.stamp.day_number  = day_info.day_number;
         s2_stage_in.stamp.hour        = s1_item_ff.hour;
         s2_stage_in.stamp.minute      = s1_item_ff.minute;
         s2_stage_in.stamp.second      = s1_item_ff.second;
         s2_stage_in.stamp.millisecond = s1_item_ff.millisecond;
      end

      // Load the response register
      if (out_ready) begin
         rsp_valid_in = s2_valid_ff;
         rsp_data_in  = result;
      end

      if (ref_write) begin
         ref_stamp_in = s2_stage_ff.stamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ref_stamp_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         ref_stamp_ff <= ref_stamp_in;
      end
      s1_item_ff  <= s1_item_in;
      s2_stage_ff <= s2_stage_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   // An invalid response carries a zero duration
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.invalid |->
         (rsp_data_ff.elapsed_days == 22'd0) && (rsp_data_ff.elapsed_hours == 5'd0)
         && (rsp_data_ff.elapsed_minutes == 6'd0) && (rsp_data_ff.elapsed_seconds == 6'd0)
         && (rsp_data_ff.elapsed_milliseconds == 10'd0))
      else $error("invalid response with non-zero duration");

   // Sub-day remainders stay within their radix
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         (rsp_data_ff.elapsed_hours <= 5'd23) && (rsp_data_ff.elapsed_minutes <= 6'd59)
         && (rsp_data_ff.elapsed_seconds <= 6'd59)
         && (rsp_data_ff.elapsed_milliseconds <= 10'd999))
      else $error("elapsed remainder out of range");

   // The reference changes only on a valid store leaving the day-number stage
   assert property (@(posedge clock) disable iff (reset)
      !ref_write |=> $stable(ref_stamp_ff))
      else $error("reference changed without a store");

   assert property (@(posedge clock) disable iff (reset)
      ref_write |=> (ref_stamp_ff == $past(s2_stage_ff.stamp)))
      else $error("reference not loaded from the store request");

endmodule

### rtl/ted_day_number.sv
`timescale 1ns / 1ps
// Day number and field validation for one timestamp.
module ted_day_number (
   input  ted_pkg::req_payload_type item,
   output ted_pkg::day_info_type    info
);

   logic [13:0] prev_year;
   logic [26:0] quot_prod;
   logic [7:0]  prev_cent;
   logic [13:0] prev_cent_x100;
   logic [6:0]  prev_rem;
   logic        century_year;
   logic [7:0]  year_cent;
   logic        leap;
   logic [23:0] total;
   logic        date_ok;
   logic        clock_ok;

   assign prev_year      = item.year - 14'd1;
   assign quot_prod      = 27'(prev_year) * 27'(ted_pkg::RECIP_100);
   assign prev_cent      = quot_prod[26:ted_pkg::RECIP_SHIFT];
   assign prev_cent_x100 = 14'(prev_cent) * 14'd100;
   assign prev_rem       = 7'(prev_year - prev_cent_x100);
   // year is a century year exactly when year - 1 ends in 99
   assign century_year   = (prev_rem == 7'd99);
   assign year_cent      = prev_cent + 8'(century_year);
   assign leap = century_year ? (year_cent[1:0] == 2'd0) : (item.year[1:0] == 2'd0);

   assign total = 24'(prev_year) * 24'd365
                + 24'(prev_year[13:2])
                - 24'(prev_cent)
                + 24'(prev_cent[7:2])
                + 24'(ted_pkg::days_before_month(item.month))
                + 24'(leap && (item.month > 4'd2))
                + 24'(item.day);

   assign date_ok = (item.year >= 14'd1) && (item.year <= 14'(ted_pkg::MAX_YEAR))
                 && (item.month >= 4'd1) && (item.month <= 4'd12)
                 && (item.day >= 5'd1)
                 && (item.day <= ted_pkg::month_length(item.month, leap));

   assign clock_ok = (item.hour <= 5'd23) && (item.minute <= 6'd59)
                  && (item.second <= 6'd59) && (item.millisecond <= 10'd999);

   assign info.invalid    = !(date_ok && clock_ok);
   assign info.day_number = total[21:0];

endmodule

### rtl/ted_elapsed.sv
`timescale 1ns / 1ps
// Ordering and borrow-chain subtraction against the reference timestamp.
module ted_elapsed (
   input  ted_pkg::stage_type       item,
   input  ted_pkg::stamp_type       ref_stamp,
   output ted_pkg::rsp_payload_type result
);

   ted_pkg::stamp_type late;
   ted_pkg::stamp_type early;
   logic        later;
   logic        borrow_ms, borrow_sec, borrow_min, borrow_hour;
   logic [6:0]  need_sec, need_min;
   logic [5:0]  need_hour;
   logic [10:0] ms_diff;
   logic [6:0]  sec_diff, min_diff;
   logic [5:0]  hour_diff;
   logic [21:0] day_diff;

   assign later = (item.stamp > ref_stamp);
   assign late  = later ? item.stamp : ref_stamp;
   assign early = later ? ref_stamp  : item.stamp;

   assign borrow_ms = (late.millisecond < early.millisecond);
   assign ms_diff   = 11'(late.millisecond) + (borrow_ms ? 11'd1000 : 11'd0)
                    - 11'(early.millisecond);

   assign need_sec   = 7'(early.second) + 7'(borrow_ms);
   assign borrow_sec = (7'(late.second) < need_sec);
   assign sec_diff   = 7'(late.second) + (borrow_sec ? 7'd60 : 7'd0) - need_sec;

   assign need_min   = 7'(early.minute) + 7'(borrow_sec);
   assign borrow_min = (7'(late.minute) < need_min);
   assign min_diff   = 7'(late.minute) + (borrow_min ? 7'd60 : 7'd0) - need_min;

   assign need_hour   = 6'(early.hour) + 6'(borrow_min);
   assign borrow_hour = (6'(late.hour) < need_hour);
   assign hour_diff   = 6'(late.hour) + (borrow_hour ? 6'd24 : 6'd0) - need_hour;

   assign day_diff = late.day_number - early.day_number - 22'(borrow_hour);

   always_comb begin
      result = '0;
      if (item.invalid) begin
         result.invalid = 1'b1;
      end else if (item.action == ted_pkg::ACTION_MEASURE) begin
         result.elapsed_days         = day_diff;
         result.elapsed_hours        = hour_diff[4:0];
         result.elapsed_minutes      = min_diff[5:0];
         result.elapsed_seconds      = sec_diff[5:0];
         result.elapsed_milliseconds = ms_diff[9:0];
      end
   end

endmodule
